// ===== rtl/obct_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the obstacle clearance trend scorer.
// No dependencies; used by obct_ctrl, obct_datapath and the top level.
package obct_pkg;

   // Configuration register indexes
   localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
   localparam logic [2:0] REG_CELL_SIZE  = 3'd2;
   localparam logic [2:0] REG_NEAR_LIMIT = 3'd3;
   localparam logic [2:0] REG_PENALTY    = 3'd4;

   // Field widths
   localparam int POSE_W  = 21;   // pose and origin coordinate, mm
   localparam int LANES   = 4;    // poses compared side by side
   localparam int COORD_W = 25;   // signed coordinate in half-mm
   localparam int ABS_W   = 24;   // magnitude of a coordinate difference
   localparam int SQ_W    = 2 * ABS_W;
   localparam int SUM_W   = SQ_W + 1;
   localparam int DIST_W  = 42;   // squared distance in quarter-mm^2, saturated
   localparam int LIM_W   = 34;   // squared near limit in quarter-mm^2

   // 1000 m squared, in quarter-mm^2
   localparam logic [DIST_W-1:0] SENTINEL_Q = 42'd4000000000000;

   typedef struct packed {
      logic [POSE_W-1:0] origin_x;
      logic [POSE_W-1:0] origin_y;
      logic [9:0]        cell_size;
      logic [15:0]       near_limit;
      logic [7:0]        penalty;
   } obct_cfg_type;

   // Controller -> datapath / output stage
   typedef struct packed {
      logic start;     // latch poses, reset minima
      logic step;      // one grid cell issued this cycle
      logic row_end;   // issued cell is the last of its row
      logic load;      // move the finished result to the output register
   } obct_cmd_type;

   // Datapath / output stage -> controller
   typedef struct packed {
      logic pipe_busy;
      logic out_free;
   } obct_status_type;

   // Packed so that score_tenths sits in the lowest bits
   typedef struct packed {
      logic [45:0] nearest_sq_mm2;
      logic        moving_away;
      logic        is_near;
      logic [7:0]  score_tenths;
   } obct_result_type;

endpackage

// ===== rtl/obct_grid_mem.sv =====
`timescale 1ns / 1ps
// Occupancy grid storage: one bit per cell, one write and one registered read port.
// No dependencies.
module obct_grid_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_data_ff
);

   logic mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ===== rtl/obct_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: grid clearing pass, cell scan, pipeline drain and result hand-off.
// Depends on obct_pkg.
module obct_ctrl #(
   parameter int GRID_W = 64,
   parameter int GRID_H = 64,
   parameter int AW     = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     score_start,
   input  obct_pkg::obct_status_type status,
   output obct_pkg::obct_cmd_type    cmd,
   output logic                     idle,
   output logic                     clear_we,
   output logic [AW-1:0]            addr
);

   localparam int CELLS = GRID_W * GRID_H;
   localparam int CW    = (GRID_W > 1) ? $clog2(GRID_W) : 1;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [CW-1:0] col_ff, col_in;
   logic          addr_last;
   logic          col_last;

   assign addr_last = (addr_ff == AW'(CELLS - 1));
   assign col_last  = (col_ff == CW'(GRID_W - 1));

   // Next state and counters
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      col_in   = col_ff;
      cmd      = '0;
      clear_we = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clear_we = 1'b1;
            if (addr_last) begin
               state_in = ST_IDLE;
               addr_in  = '0;
            end else begin
               addr_in = AW'(addr_ff + 1'b1);
            end
         end
         ST_IDLE: begin
            if (score_start) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
               addr_in   = '0;
               col_in    = '0;
            end
         end
         ST_SCAN: begin
            cmd.step    = 1'b1;
            cmd.row_end = col_last;
            if (addr_last) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = AW'(addr_ff + 1'b1);
               col_in  = col_last ? '0 : CW'(col_ff + 1'b1);
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff  <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         col_ff   <= col_in;
      end
   end

   assign idle = (state_ff == ST_IDLE);
   assign addr = addr_ff;

endmodule

// ===== rtl/obct_datapath.sv =====
`timescale 1ns / 1ps
// Distance datapath: cell center accumulators, four pose lanes of
// difference, square and running minimum, and the final score logic.
// Depends on obct_pkg.
module obct_datapath (
   input  logic                                         clock,
   input  logic                                         reset,
   input  obct_pkg::obct_cmd_type                        cmd,
   input  obct_pkg::obct_cfg_type                        cfg,
   input  logic [2*obct_pkg::LANES*obct_pkg::POSE_W-1:0] poses,
   input  logic                                         occ,
   output logic                                         pipe_busy,
   output obct_pkg::obct_result_type                     result
);

   localparam int CW = obct_pkg::COORD_W;
   localparam int PW = obct_pkg::POSE_W;
   localparam int NL = obct_pkg::LANES;

   // Latched poses in half-mm
   logic signed [CW-1:0] px_ff [NL];
   logic signed [CW-1:0] py_ff [NL];

   // Cell center of the cell being issued
   logic signed [CW-1:0] wx_ff, wy_ff;
   logic signed [CW-1:0] wx_row, wy_row, cs2, cs1;

   // Pipeline stages
   logic                    s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic signed [CW-1:0]    s1_wx_ff, s1_wy_ff;
   logic [obct_pkg::ABS_W-1:0] s2_dx_ff [NL];
   logic [obct_pkg::ABS_W-1:0] s2_dy_ff [NL];
   logic [obct_pkg::SQ_W-1:0]  s3_sx_ff [NL];
   logic [obct_pkg::SQ_W-1:0]  s3_sy_ff [NL];

   logic [obct_pkg::DIST_W-1:0] min_ff [NL];
   logic [obct_pkg::LIM_W-1:0]  lim_ff;

   logic signed [CW-1:0]        diff_x [NL];
   logic signed [CW-1:0]        diff_y [NL];
   logic [obct_pkg::SUM_W-1:0]  sum    [NL];

   // Center of column 0 / row 0 and the column pitch, half-mm
   assign cs1    = {{(CW - 10){1'b0}}, cfg.cell_size};
   assign cs2    = {{(CW - 11){1'b0}}, cfg.cell_size, 1'b0};
   assign wx_row = {{(CW - PW - 1){cfg.origin_x[PW-1]}}, cfg.origin_x, 1'b0} + cs1;
   assign wy_row = {{(CW - PW - 1){cfg.origin_y[PW-1]}}, cfg.origin_y, 1'b0} + cs1;

   // Pose latch, squared limit and center accumulators
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         for (int l = 0; l < NL; l++) begin
            px_ff[l] <= {{(CW - PW - 1){poses[2*l*PW + PW - 1]}},
                         poses[2*l*PW +: PW], 1'b0};
            py_ff[l] <= {{(CW - PW - 1){poses[(2*l+1)*PW + PW - 1]}},
                         poses[(2*l+1)*PW +: PW], 1'b0};
         end
         // limit squared, times four for quarter-mm^2
         lim_ff <= {32'(cfg.near_limit) * 32'(cfg.near_limit), 2'b00};
         wx_ff  <= wx_row;
         wy_ff  <= wy_row;
      end else if (cmd.step) begin
         if (cmd.row_end) begin
            wx_ff <= wx_row;
            wy_ff <= wy_ff + cs2;
         end else begin
            wx_ff <= wx_ff + cs2;
         end
      end
   end

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.step;
         s2_vld_ff <= s1_vld_ff & occ;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   // Coordinate differences per lane
   always_comb begin
      for (int l = 0; l < NL; l++) begin
         diff_x[l] = s1_wx_ff - px_ff[l];
         diff_y[l] = s1_wy_ff - py_ff[l];
      end
   end

   // Stage 1: center aligned with the grid read; stage 2: magnitudes;
   // stage 3: squares
   always_ff @(posedge clock) begin
      s1_wx_ff <= wx_ff;
      s1_wy_ff <= wy_ff;
      for (int l = 0; l < NL; l++) begin
         s2_dx_ff[l] <= diff_x[l][CW-1] ? obct_pkg::ABS_W'(-diff_x[l])
                                        : obct_pkg::ABS_W'(diff_x[l]);
         s2_dy_ff[l] <= diff_y[l][CW-1] ? obct_pkg::ABS_W'(-diff_y[l])
                                        : obct_pkg::ABS_W'(diff_y[l]);
         s3_sx_ff[l] <= s2_dx_ff[l] * s2_dx_ff[l];
         s3_sy_ff[l] <= s2_dy_ff[l] * s2_dy_ff[l];
      end
   end

   // Stage 4: running minimum per pose
   always_comb begin
      for (int l = 0; l < NL; l++) begin
         sum[l] = {1'b0, s3_sx_ff[l]} + {1'b0, s3_sy_ff[l]};
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < NL; l++) begin
         if (cmd.start) begin
            min_ff[l] <= obct_pkg::SENTINEL_Q;
         end else if (s3_vld_ff &&
                      sum[l] < {{(obct_pkg::SUM_W - obct_pkg::DIST_W){1'b0}}, min_ff[l]}) begin
            min_ff[l] <= sum[l][obct_pkg::DIST_W-1:0];
         end
      end
   end

   assign pipe_busy = s1_vld_ff | s2_vld_ff | s3_vld_ff;

   // Trend check and score
   always_comb begin
      result.is_near = (min_ff[0] <=
                        {{(obct_pkg::DIST_W - obct_pkg::LIM_W){1'b0}}, lim_ff});
      result.moving_away = (min_ff[0] <= min_ff[1]) && (min_ff[1] <= min_ff[2]) &&
                           (min_ff[2] <= min_ff[3]);
      result.score_tenths = (result.is_near && !result.moving_away) ? cfg.penalty
                                                                    : 8'd0;
      result.nearest_sq_mm2 = {6'd0, min_ff[0][obct_pkg::DIST_W-1:2]};
   end

endmodule

// ===== rtl/obstacle_clearance_trend_scorer.sv =====
`timescale 1ns / 1ps
// A score transaction scans the GRID_W*GRID_H cells, one per cycle, then drains a pipeline
// and loads the output register: rsp_tvalid rises once the result is loaded (later while
// an earlier result waits); one score is in work at a time. After reset a clearing pass
// over all GRID_W*GRID_H cells empties the grid; no request is taken until it ends.
// Configuration registers reset to their defaults.
// Top level: configuration registers, request decode, output register.
// Depends on obct_pkg, obct_grid_mem, obct_ctrl, obct_datapath.
module obstacle_clearance_trend_scorer #(
   parameter int GRID_W = 64,
   parameter int GRID_H = 64
) (
   input  logic         clock,
   input  logic         reset,
   // Requests
   input  logic         req_tvalid,
   output logic         req_tready,
   // cell_x[5:0], cell_y[11:6], cell_cost[19:12], pose0_x[40:20], pose0_y[61:41],
   // pose1_x[82:62], pose1_y[103:83], pose2_x[124:104], pose2_y[145:125],
   // pose3_x[166:146], pose3_y[187:167], zero pad[191:188]
   input  logic [191:0] req_tdata,
   // req_type[0]
   input  logic [0:0]   req_tuser,
   // Results
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // score_tenths[7:0], is_near[8], moving_away[9], nearest_sq_mm2[55:10]
   output logic [55:0]  rsp_tdata,
   // Configuration writes
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [20:0]  csr_data
);

   localparam int CELLS = GRID_W * GRID_H;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

   obct_pkg::obct_cfg_type    cfg_ff;
   obct_pkg::obct_cmd_type    cmd;
   obct_pkg::obct_status_type status;
   obct_pkg::obct_result_type result;

   logic          req_fire, score_start, cell_write, cell_in_grid;
   logic          idle, clear_we, occ;
   logic [AW-1:0] scan_addr, cell_addr;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic          mem_wdata;
   logic          rsp_valid_ff;
   logic [55:0]   rsp_data_ff;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x   <= '0;
         cfg_ff.origin_y   <= '0;
         cfg_ff.cell_size  <= 10'd50;
         cfg_ff.near_limit <= 16'd300;
         cfg_ff.penalty    <= 8'd75;
      end else if (csr_valid) begin
         case (csr_index)
            obct_pkg::REG_ORIGIN_X:   cfg_ff.origin_x   <= csr_data;
            obct_pkg::REG_ORIGIN_Y:   cfg_ff.origin_y   <= csr_data;
            obct_pkg::REG_CELL_SIZE:  cfg_ff.cell_size  <= csr_data[9:0];
            obct_pkg::REG_NEAR_LIMIT: cfg_ff.near_limit <= csr_data[15:0];
            obct_pkg::REG_PENALTY:    cfg_ff.penalty    <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Request decode
   assign req_tready   = idle;
   assign req_fire     = req_tvalid & req_tready;
   assign score_start  = req_fire & req_tuser[0];
   assign cell_in_grid = (32'(req_tdata[5:0]) < GRID_W) && (32'(req_tdata[11:6]) < GRID_H);
   assign cell_write   = req_fire & ~req_tuser[0] & cell_in_grid;
   assign cell_addr    = AW'(32'(req_tdata[11:6]) * GRID_W + 32'(req_tdata[5:0]));

   // Grid write port: clearing pass or cell write
   assign mem_we    = clear_we | cell_write;
   assign mem_waddr = clear_we ? scan_addr : cell_addr;
   assign mem_wdata = ~clear_we & (req_tdata[19:12] != 8'd0);

   obct_grid_mem #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_grid_mem (
      .clock      (clock),
      .wr_en      (mem_we),
      .wr_addr    (mem_waddr),
      .wr_data    (mem_wdata),
      .rd_addr    (scan_addr),
      .rd_data_ff (occ)
   );

   assign status.out_free = ~rsp_valid_ff | rsp_tready;

   obct_ctrl #(
      .GRID_W (GRID_W),
      .GRID_H (GRID_H),
      .AW     (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .score_start (score_start),
      .status      (status),
      .cmd         (cmd),
      .idle        (idle),
      .clear_we    (clear_we),
      .addr        (scan_addr)
   );

   obct_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg_ff),
      .poses     (req_tdata[187:20]),
      .occ       (occ),
      .pipe_busy (status.pipe_busy),
      .result    (result)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      clear_we |-> !req_tready)
      else $error("request taken during grid clearing pass");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> status.out_free)
      else $error("result loaded over an untaken result");

   a_score_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[7:0] != 8'd0) |-> (rsp_tdata[8] && !rsp_tdata[9]))
      else $error("nonzero score without near and shrinking clearance");

   a_nearest_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[55:10] <= 46'd1000000000000))
      else $error("nearest distance above the sentinel");

endmodule
